### hw/rtl/ske_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key set package
// Shared widths, operation and status codes, and the cell control struct.
// ----------------------------------------------------------------------------
package ske_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int KEY_W        = 32;
   localparam int KIND_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int FIELD_W      = 5;

   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctrl_type;

endpackage
`default_nettype wire

### hw/rtl/sorted_key_set_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key set engine
// Keeps distinct signed keys in ascending order in a row of compare/shift
// cells; each item searches, inserts or removes one key.
// The result strobe is registered: an accepted item sets the pending (busy)
// register, which in turn sets the result-valid register. Busy is high for
// the one cycle in which the whole cell row compares and shifts; no item is
// taken while busy. Reset clears the key count and the cell valid flags
// at once; no clearing pass. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module sorted_key_set_engine_top import ske_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [FIELD_W-1:0]      rsp_position,
   output logic [FIELD_W-1:0]      rsp_count
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   logic                    pending_ff;
   logic [KIND_W-1:0]       kind_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff, status_in;
   logic [FIELD_W-1:0]      rsp_position_ff, rsp_count_ff;

   logic signed [KEY_W-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0]     cell_valid, cell_less, cell_eq, cell_at_pos;
   cell_ctrl_type           ctrl;
   logic                    found;
   logic [CNT_W-1:0]        position;
   logic                    full;

   // cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic                    lo_less, lo_valid, up_valid;
      logic signed [KEY_W-1:0] lo_key, up_key;

      if (g == 0) begin : g_bottom
         assign lo_less  = 1'b1;
         assign lo_key   = key_ff;
         assign lo_valid = 1'b0;
      end else begin : g_mid_lo
         assign lo_less  = cell_less[g-1];
         assign lo_key   = cell_key[g-1];
         assign lo_valid = cell_valid[g-1];
      end

      if (g == CAPACITY-1) begin : g_top
         assign up_key   = key_ff;
         assign up_valid = 1'b0;
      end else begin : g_mid_up
         assign up_key   = cell_key[g+1];
         assign up_valid = cell_valid[g+1];
      end

      ske_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cmd_key     (key_ff),
         .lower_less  (lo_less),
         .lower_key   (lo_key),
         .lower_valid (lo_valid),
         .upper_key   (up_key),
         .upper_valid (up_valid),
         .key         (cell_key[g]),
         .valid       (cell_valid[g]),
         .less        (cell_less[g]),
         .eq          (cell_eq[g]),
         .at_pos      (cell_at_pos[g])
      );
   end

   ske_locate #(
      .CAPACITY (CAPACITY)
   ) u_locate (
      .at_pos   (cell_at_pos),
      .eq       (cell_eq),
      .all_less (cell_less[CAPACITY-1]),
      .found    (found),
      .position (position)
   );

   assign full = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      ctrl      = '0;
      count_in  = count_ff;
      status_in = found ? STATUS_DONE : STATUS_ABSENT;
      unique case (kind_ff)
         KIND_INSERT: begin
            if (found) begin
               status_in = STATUS_PRESENT;
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_DONE;
               ctrl.ins  = pending_ff;
               count_in  = count_ff + 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (found) begin
               ctrl.rem = pending_ff;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         pending_ff   <= start && !pending_ff;
         rsp_valid_ff <= pending_ff;
         if (pending_ff) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !pending_ff) begin
         kind_ff <= req_kind;
         key_ff  <= req_key;
      end
      if (pending_ff) begin
         rsp_status_ff   <= status_in;
         rsp_position_ff <= FIELD_W'(position);
         rsp_count_ff    <= FIELD_W'(count_in);
      end
   end

   assign busy         = pending_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

`ifndef ASSERT_OFF
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(pending_ff))
      else $error("result strobe without a preceding busy cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("key count exceeds capacity");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("cell valid flags disagree with key count");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_eq))
      else $error("key matched in more than one cell");
`endif

endmodule
`default_nettype wire

### hw/rtl/ske_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key set cell
// Holds one key slot, compares it with the command key and shifts up or
// down with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module ske_cell import ske_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctrl_type           ctrl,
   input  logic signed [KEY_W-1:0] cmd_key,
   input  logic                    lower_less,
   input  logic signed [KEY_W-1:0] lower_key,
   input  logic                    lower_valid,
   input  logic signed [KEY_W-1:0] upper_key,
   input  logic                    upper_valid,
   output logic signed [KEY_W-1:0] key,
   output logic                    valid,
   output logic                    less,
   output logic                    eq,
   output logic                    at_pos
);

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    valid_ff, valid_in;

   assign less   = valid_ff && (key_ff < cmd_key);
   assign eq     = valid_ff && (key_ff == cmd_key);
   assign at_pos = lower_less && !less;
   assign key    = key_ff;
   assign valid  = valid_ff;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctrl.ins) begin
         if (at_pos) begin
            key_in   = cmd_key;
            valid_in = 1'b1;
         end else if (!less) begin
            key_in   = lower_key;
            valid_in = lower_valid;
         end
      end else if (ctrl.rem && !less) begin
         key_in   = upper_key;
         valid_in = upper_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule
`default_nettype wire

### hw/rtl/ske_locate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key set locator
// Encodes the one-hot insertion point of the cell row into a position and
// reduces the match flags into a found flag.
// ----------------------------------------------------------------------------
module ske_locate import ske_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic [CAPACITY-1:0]                at_pos,
   input  logic [CAPACITY-1:0]                eq,
   input  logic                               all_less,
   output logic                               found,
   output logic [$clog2(CAPACITY+1)-1:0]      position
);

   localparam int POS_W = $clog2(CAPACITY+1);

   always_comb begin
      position = all_less ? POS_W'(CAPACITY) : '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (at_pos[i]) begin
            position = position | POS_W'(i);
         end
      end
   end

   assign found = |eq;

endmodule
`default_nettype wire

### tb/sv/sorted_key_set_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key set engine testbench
// Sends search, insert and remove items over the start/busy port and checks
// each result strobe against a software copy of the sorted set: directed
// corner items first, then bursts of random traffic that fill and drain the
// store, with random gaps between items.
// ----------------------------------------------------------------------------
module sorted_key_set_engine_top_tb;
   import ske_pkg::*;

   localparam int CAP = CAPACITY_DEF;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
   localparam int POOL_SIZE = 20;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  position;
      logic [FIELD_W-1:0]  count;
   } set_outcome_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [KIND_W-1:0]       req_kind;
   logic signed [KEY_W-1:0] req_key;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [FIELD_W-1:0]      rsp_position;
   logic [FIELD_W-1:0]      rsp_count;

   logic signed [KEY_W-1:0] held_keys [CAP];
   int                      held_count;
   set_outcome_type         pending_outcomes [$];
   int                      error_count;
   int                      results_seen;

   sorted_key_set_engine_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("sorted_key_set_engine_top verification failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // applies one operation to the set copy and returns the result it causes
   function automatic set_outcome_type apply_set_op(input logic [KIND_W-1:0] kind,
                                                    input logic signed [KEY_W-1:0] key);
      set_outcome_type res;
      int              pos;
      bit              hit;
      pos = 0;
      while (pos < held_count && held_keys[pos] < key) pos++;
      hit = (pos < held_count) && (held_keys[pos] == key);
      res.position = FIELD_W'(pos);
      case (kind)
         KIND_INSERT: begin
            if (hit) begin
               res.status = STATUS_PRESENT;
            end else if (held_count >= CAP) begin
               res.status = STATUS_FULL;
            end else begin
               for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
               held_keys[pos] = key;
               held_count++;
               res.status = STATUS_DONE;
            end
         end
         KIND_REMOVE: begin
            if (hit) begin
               for (int i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
               held_count--;
               res.status = STATUS_DONE;
            end else begin
               res.status = STATUS_ABSENT;
            end
         end
         default: begin
            res.status = hit ? STATUS_DONE : STATUS_ABSENT;
         end
      endcase
      res.count = FIELD_W'(held_count);
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // start is left high when gap is zero so back-to-back items need no toggle
   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic signed [KEY_W-1:0] key,
                            input int gap);
      start    <= 1'b1;
      req_kind <= kind;
      req_key  <= key;
      do @(posedge clock); while (busy);
      pending_outcomes.push_back(apply_set_op(kind, key));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : check_results
      set_outcome_type exp;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("result %0d with no item outstanding", results_seen));
         end else begin
            exp = pending_outcomes.pop_front();
            if (rsp_status !== exp.status)
               report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                         results_seen, rsp_status, exp.status));
            if (rsp_position !== exp.position)
               report_mismatch($sformatf("result %0d: position %0d, expected %0d",
                                         results_seen, rsp_position, exp.position));
            if (rsp_count !== exp.count)
               report_mismatch($sformatf("result %0d: count %0d, expected %0d",
                                         results_seen, rsp_count, exp.count));
         end
      end
   end

   // empty store, front/back inserts, duplicates, unused kind, end removals
   task automatic test_basic_ops();
      send_item(KIND_SEARCH, 32'sd0, pick_gap());
      send_item(KIND_REMOVE, 32'sd5, pick_gap());
      send_item(KIND_INSERT, 32'sd0, pick_gap());
      send_item(KIND_INSERT, KEY_MIN, pick_gap());
      send_item(KIND_INSERT, KEY_MAX, pick_gap());
      send_item(KIND_INSERT, -32'sd1, pick_gap());
      send_item(KIND_INSERT, 32'sd0, pick_gap());
      send_item(KIND_SEARCH, KEY_MAX, pick_gap());
      send_item(KIND_UNUSED, KEY_MIN, pick_gap());
      send_item(KIND_REMOVE, KEY_MIN, pick_gap());
      send_item(KIND_REMOVE, KEY_MAX, pick_gap());
      send_item(KIND_SEARCH, 32'sd1, pick_gap());
   endtask

   // fill to capacity, then refused insert, duplicate at full, middle removal
   task automatic test_full_store();
      for (int i = 0; i < CAP - 2; i++) send_item(KIND_INSERT, 1000 * i - 6500, 0);
      send_item(KIND_INSERT, 32'sd77, pick_gap());
      send_item(KIND_INSERT, 32'sd0, pick_gap());
      send_item(KIND_REMOVE, 32'sd500, pick_gap());
      send_item(KIND_INSERT, KEY_MIN, pick_gap());
      send_item(KIND_SEARCH, KEY_MAX, pick_gap());
   endtask

   // bursts that lean toward filling, draining or mixing the set
   task automatic test_random_traffic();
      logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
      logic [KIND_W-1:0]       kind;
      logic signed [KEY_W-1:0] key;
      int                      insert_pct;
      int                      remove_pct;
      int                      r;
      bit                      quiet;
      for (int burst = 0; burst < 20; burst++) begin
         key_pool[0] = KEY_MIN;
         key_pool[1] = KEY_MAX;
         key_pool[2] = 32'sd0;
         for (int i = 3; i < POOL_SIZE; i++)
            key_pool[i] = (i % 2) ? $urandom : int'($urandom_range(0, 40)) - 20;
         case (burst % 3)
            0: begin insert_pct = 65; remove_pct = 20; end
            1: begin insert_pct = 20; remove_pct = 65; end
            default: begin insert_pct = 40; remove_pct = 40; end
         endcase
         quiet = ($urandom_range(0, 3) == 0);
         repeat (40) begin
            r = $urandom_range(0, 99);
            if (r < insert_pct) kind = KIND_INSERT;
            else if (r < insert_pct + remove_pct) kind = KIND_REMOVE;
            else kind = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : KIND_SEARCH;
            r = $urandom_range(0, 99);
            if (r < 75) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (r < 90 && held_count > 0) key = held_keys[$urandom_range(0, held_count - 1)];
            else key = $urandom;
            send_item(kind, key, quiet ? 0 : pick_gap());
         end
      end
   endtask

   initial begin : main_sequence
      int waited;
      error_count  = 0;
      results_seen = 0;
      held_count   = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_kind <= KIND_SEARCH;
      req_key  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_full_store();
      test_random_traffic();

      start <= 1'b0;
      waited = 0;
      while (pending_outcomes.size() > 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (pending_outcomes.size() > 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_outcomes.size()));

      if (error_count == 0) begin
         $display("sorted_key_set_engine_top verification clean");
      end else begin
         $display("sorted_key_set_engine_top verification failed");
      end
      $finish;
   end

endmodule

### sorted_key_set_engine_top.f
hw/rtl/ske_pkg.sv
hw/rtl/ske_cell.sv
hw/rtl/ske_locate.sv
hw/rtl/sorted_key_set_engine_top.sv
tb/sv/sorted_key_set_engine_top_tb.sv
